@@ src/erng_pkg.sv @@
// ----------------------------------------------------------------------------
// erng_pkg
// Shared types, register indexes, phase codes and arithmetic constants of the
// ultrasonic echo ranger.
// ----------------------------------------------------------------------------
package erng_pkg;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_RUN_ENABLE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ECHO_TMO   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PRE_LOW    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TRIG_PULSE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_REST_GAP   = 3'd4;

	// register reset values
	localparam logic        RST_RUN_ENABLE = 1'b1;
	localparam logic [15:0] RST_ECHO_TMO   = 16'd30000;
	localparam logic [7:0]  RST_PRE_LOW    = 8'd3;
	localparam logic [7:0]  RST_TRIG_PULSE = 8'd10;
	localparam logic [23:0] RST_REST_GAP   = 24'd100000;

	// measurement phases
	localparam logic [2:0] PH_PRE   = 3'd0;
	localparam logic [2:0] PH_PULSE = 3'd1;
	localparam logic [2:0] PH_RISE  = 3'd2;
	localparam logic [2:0] PH_HIGH  = 3'd3;
	localparam logic [2:0] PH_GAP   = 3'd4;
	localparam logic [2:0] PH_IDLE  = 3'd5;

	// distance = (width * 343 + 1000) / 2000 = ((n >> 4) * RECIP) >> RECIP_SH
	localparam logic [8:0]  SOUND_MUL  = 9'd343;
	localparam logic [24:0] ROUND_ADD  = 25'd1000;
	localparam int          RECIP_SH   = 28;
	localparam logic [21:0] RECIP      = 22'd2147484;
	localparam int          DIST_W     = 14;
	localparam logic [DIST_W-1:0] DIST_MAX = 14'd11239;

	typedef struct packed {
		logic        run_enable;
		logic [15:0] echo_tmo_us;
		logic [7:0]  pre_low_us;
		logic [7:0]  trig_pulse_us;
		logic [23:0] rest_gap_us;
	} erng_cfg_t;

	typedef struct packed {
		logic        trig_level;
		logic        sample_done;
		logic        timed_out;
		logic [31:0] seq_number;
		logic [15:0] echo_width_us;
	} erng_item_t;

endpackage

@@ src/erng_if.sv @@
// ----------------------------------------------------------------------------
// erng channel interfaces
// Valid/ready channels of the echo ranger: tick input, result output and
// configuration write.
// ----------------------------------------------------------------------------
interface erng_in_if;
	logic valid;
	logic ready;
	logic echo_level;

	modport source (output valid, output echo_level, input ready);
	modport sink   (input valid, input echo_level, output ready);
endinterface

interface erng_out_if;
	logic        valid;
	logic        ready;
	logic        trig_level;
	logic        sample_done;
	logic        timed_out;
	logic [31:0] seq_number;
	logic [15:0] echo_width_us;
	logic [13:0] range_mm;

	modport source (output valid, output trig_level, output sample_done, output timed_out,
		output seq_number, output echo_width_us, output range_mm, input ready);
	modport sink   (input valid, input trig_level, input sample_done, input timed_out,
		input seq_number, input echo_width_us, input range_mm, output ready);
endinterface

interface erng_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [erng_pkg::CFG_IDX_W-1:0]  index;
	logic [erng_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

@@ src/erng_cfg.sv @@
// ----------------------------------------------------------------------------
// erng_cfg
// Configuration register file; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module erng_cfg (
	input  logic               clk,
	input  logic               arst_n,
	erng_cfg_if.sink           cfg,
	output erng_pkg::erng_cfg_t regs
);
	import erng_pkg::*;

	erng_cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	// update one register per transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.run_enable    <= RST_RUN_ENABLE;
			regs_q.echo_tmo_us   <= RST_ECHO_TMO;
			regs_q.pre_low_us    <= RST_PRE_LOW;
			regs_q.trig_pulse_us <= RST_TRIG_PULSE;
			regs_q.rest_gap_us   <= RST_REST_GAP;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_RUN_ENABLE: regs_q.run_enable    <= cfg.data[0];
				REG_ECHO_TMO:   regs_q.echo_tmo_us   <= cfg.data[15:0];
				REG_PRE_LOW:    regs_q.pre_low_us    <= cfg.data[7:0];
				REG_TRIG_PULSE: regs_q.trig_pulse_us <= cfg.data[7:0];
				REG_REST_GAP:   regs_q.rest_gap_us   <= cfg.data[23:0];
				default: ;
			endcase
		end
	end
endmodule

@@ src/erng_seq.sv @@
// ----------------------------------------------------------------------------
// erng_seq
// Measurement sequencer: steps the phase once per tick and registers the
// tick's trigger level and report into the first pipeline stage.
// ----------------------------------------------------------------------------
module erng_seq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  erng_pkg::erng_cfg_t  regs,
	input  logic                 adv,
	input  logic                 in_valid,
	input  logic                 echo_level,
	output logic                 v_s1,
	output erng_pkg::erng_item_t item_s1
);
	import erng_pkg::*;

	logic [2:0]  phase_q;
	logic [23:0] tick_q;
	logic [31:0] seq_q;
	logic        valid_s1;
	erng_item_t  data_s1;

	logic [2:0]  ph;
	logic [23:0] tc;
	erng_item_t  res;
	logic        take;

	assign take    = in_valid && adv;
	assign v_s1    = valid_s1;
	assign item_s1 = data_s1;

	// resolve zero-length phases, then act on the phase this tick lands in
	always_comb begin
		ph  = phase_q;
		tc  = tick_q;
		res = '0;

		if (ph == PH_GAP && tc >= regs.rest_gap_us) begin
			ph = PH_IDLE;
			tc = '0;
		end
		if (!(ph inside {PH_PRE, PH_PULSE, PH_RISE, PH_HIGH, PH_GAP})) begin
			ph = PH_IDLE;
			if (regs.run_enable) begin
				ph = PH_PRE;
				tc = '0;
			end
		end
		if (ph == PH_PRE && tc >= {16'd0, regs.pre_low_us}) begin
			ph = PH_PULSE;
			tc = '0;
		end
		if (ph == PH_PULSE && tc >= {16'd0, regs.trig_pulse_us}) begin
			ph = PH_RISE;
			tc = '0;
		end

		case (ph)
			PH_PRE: begin
				tc = tc + 24'd1;
			end
			PH_PULSE: begin
				res.trig_level = 1'b1;
				tc = tc + 24'd1;
			end
			PH_RISE: begin
				if (tc >= {8'd0, regs.echo_tmo_us}) begin
					res.sample_done = 1'b1;
					res.timed_out   = 1'b1;
				end else if (echo_level) begin
					ph = PH_HIGH;
					tc = 24'd1;
				end else begin
					tc = tc + 24'd1;
				end
			end
			PH_HIGH: begin
				if (tc >= {8'd0, regs.echo_tmo_us}) begin
					res.sample_done = 1'b1;
					res.timed_out   = 1'b1;
				end else if (!echo_level) begin
					res.sample_done   = 1'b1;
					res.echo_width_us = tc[15:0];
				end else begin
					tc = tc + 24'd1;
				end
			end
			PH_GAP: begin
				tc = tc + 24'd1;
			end
			default: ;
		endcase

		if (res.sample_done) begin
			res.seq_number = seq_q;
			ph = PH_GAP;
			tc = '0;
		end
	end

	// advance phase state on each accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_PRE;
			tick_q  <= '0;
			seq_q   <= '0;
		end else if (take) begin
			phase_q <= ph;
			tick_q  <= tc;
			if (res.sample_done) begin
				seq_q <= seq_q + 32'd1;
			end
		end
	end

	// first pipeline stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			data_s1 <= res;
		end
	end
endmodule

@@ src/erng_dist.sv @@
// ----------------------------------------------------------------------------
// erng_dist
// Distance datapath: scales the echo width by the speed of sound, then
// divides by 2000 through a reciprocal multiply. Two pipeline stages.
// ----------------------------------------------------------------------------
module erng_dist (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        adv,
	input  logic                        v_s1,
	input  erng_pkg::erng_item_t        item_s1,
	output logic                        v_s3,
	output erng_pkg::erng_item_t        item_s3,
	output logic [erng_pkg::DIST_W-1:0] dist_s3
);
	import erng_pkg::*;

	logic [24:0]       scaled;
	logic [42:0]       prod;
	logic              valid_s2;
	logic              valid_s3;
	erng_item_t        data_s2;
	erng_item_t        data_s3;
	logic [20:0]       quot_in_s2;
	logic [DIST_W-1:0] dist_q_s3;

	// width * 343 + 1000, then drop the factor 16 of 2000
	assign scaled = {9'd0, item_s1.echo_width_us} * {16'd0, SOUND_MUL} + ROUND_ADD;

	// divide by 125 through the reciprocal
	assign prod = {22'd0, quot_in_s2} * {21'd0, RECIP};

	assign v_s3    = valid_s3;
	assign item_s3 = data_s3;
	assign dist_s3 = dist_q_s3;

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= v_s1;
			valid_s3 <= valid_s2;
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		if (adv) begin
			data_s2    <= item_s1;
			quot_in_s2 <= scaled[24:4];
			data_s3    <= data_s2;
			dist_q_s3  <= prod[RECIP_SH+DIST_W-1:RECIP_SH];
		end
	end
endmodule

@@ src/ultrasonic_echo_ranger_unit.sv @@
// A tick's result is registered in turn in the sequencer, scale and divide stages.
// Throughput: one tick per cycle; the three-stage pipeline (sequencer, scale,
// reciprocal divide) stalls as a whole only while a result waits for ready.
// Reset: arst_n clears the phase to the pre-low phase, the tick and sequence
// counters to zero, the registers to their defaults and empties the pipeline.
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger_unit
// Trigger/echo ranging sequencer with timeout, distance in millimeters.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger_unit (
	input  logic        clk,
	input  logic        arst_n,
	erng_cfg_if.sink    cfg,
	erng_in_if.sink     tick,
	erng_out_if.source  result
);
	import erng_pkg::*;

	erng_cfg_t         regs;
	logic              adv;
	logic              v_s1;
	logic              v_s3;
	erng_item_t        item_s1;
	erng_item_t        item_s3;
	logic [DIST_W-1:0] dist_s3;

	// advance the pipeline when the output stage is empty or drained
	assign adv        = !v_s3 || result.ready;
	assign tick.ready = adv;

	erng_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	erng_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.regs       (regs),
		.adv        (adv),
		.in_valid   (tick.valid),
		.echo_level (tick.echo_level),
		.v_s1       (v_s1),
		.item_s1    (item_s1)
	);

	erng_dist u_dist (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.v_s1    (v_s1),
		.item_s1 (item_s1),
		.v_s3    (v_s3),
		.item_s3 (item_s3),
		.dist_s3 (dist_s3)
	);

	// drive the result channel
	assign result.valid         = v_s3;
	assign result.trig_level    = item_s3.trig_level;
	assign result.sample_done   = item_s3.sample_done;
	assign result.timed_out     = item_s3.timed_out;
	assign result.seq_number    = item_s3.seq_number;
	assign result.echo_width_us = item_s3.echo_width_us;
	assign result.range_mm      = dist_s3;
endmodule

@@ src/erng_chk.sv @@
// ----------------------------------------------------------------------------
// erng_chk
// Port-level checks of the echo ranger result channel, bound to the top.
// ----------------------------------------------------------------------------
module erng_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic        trig_level,
	input logic        sample_done,
	input logic        timed_out,
	input logic [31:0] seq_number,
	input logic [15:0] echo_width_us,
	input logic [13:0] range_mm
);
	import erng_pkg::*;

	// hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(seq_number)
			&& $stable(echo_width_us) && $stable(range_mm) && $stable(sample_done))
		else $error("stalled result changed");

	// trigger is never driven on a report tick
	a_trig: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && sample_done |-> !trig_level)
		else $error("trigger high on report tick");

	// timeout reports carry no width or distance
	a_tmo: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && timed_out |-> sample_done && echo_width_us == 16'd0
			&& range_mm == 14'd0)
		else $error("bad timeout report");

	// non-report ticks carry only the trigger level
	a_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !sample_done |-> !timed_out && seq_number == 32'd0
			&& echo_width_us == 16'd0 && range_mm == 14'd0)
		else $error("fields set without report");

	// distance stays in range
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> range_mm <= DIST_MAX)
		else $error("distance out of range");
endmodule

bind ultrasonic_echo_ranger_unit erng_chk u_erng_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (result.valid),
	.out_ready     (result.ready),
	.trig_level    (result.trig_level),
	.sample_done   (result.sample_done),
	.timed_out     (result.timed_out),
	.seq_number    (result.seq_number),
	.echo_width_us (result.echo_width_us),
	.range_mm      (result.range_mm)
);
